// File: design/splat_rotated_blend_painter_macros.svh
// assertion macros used by the painter datapath
`ifndef SPLAT_ROTATED_BLEND_PAINTER_MACROS_SVH
`define SPLAT_ROTATED_BLEND_PAINTER_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define SRBP_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/srbp_pkg.sv
// types, command codes and sine table for the splat painter
`timescale 1ns / 1ps
package srbp_pkg;

  // width of a signed target coordinate
  localparam int PW = 14;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_SIN, ST_COS,
    ST_DIVY_INIT, ST_DIVY, ST_CAPY, ST_DIVX_INIT, ST_DIVX, ST_CAPX,
    ST_SQX, ST_SQY, ST_ROOT_INIT, ST_ROOT, ST_DSEL,
    ST_ROT_A, ST_ROT_B, ST_TX, ST_ROT_C, ST_ROT_D, ST_TY,
    ST_ADDR, ST_MEM_RD, ST_BLEND, ST_WRITE, ST_NEXT,
    ST_RES_ZERO, ST_RD_ADDR, ST_RD_MEM, ST_RES_READ
  } ctl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SIN, OP_COS,
    OP_DIV_INIT_Y, OP_DIV_INIT_X, OP_DIV_STEP, OP_CAP_Y, OP_CAP_X,
    OP_SQ_X, OP_SQ_Y, OP_ROOT_INIT, OP_ROOT_STEP, OP_DSEL,
    OP_ROT_A, OP_ROT_B, OP_TX, OP_ROT_C, OP_ROT_D, OP_TY,
    OP_ADDR, OP_MEM_RD, OP_BLEND, OP_WRITE, OP_NEXT,
    OP_RD_ADDR, OP_RES_ZERO, OP_RES_READ
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_last;
    logic root_last;
    logic blend_last;
    logic col_last;
    logic row_last;
    logic box_empty;
    logic in_image;
  } dp_status_t;

  typedef logic [14:0] qsin_tab_t [0:90];

  // quarter-wave sine in q1.14, evaluated at elaboration only
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    for (int k = 0; k <= 90; k++) begin
      x    = 64'(k) * 64'd18740330;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int i = 1; i <= 8; i++) begin
        term = (term * x2) >> 30;
        unique case (i)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          7:       term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if ((i % 2) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      tab[k] = 15'((64'(sum) + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  // sine of a whole degree count below 360, q1.14
  function automatic logic signed [15:0] sine_lookup(input logic [8:0] deg);
    logic [6:0]  idx;
    logic        neg;
    logic [14:0] mag;
    priority if (deg <= 9'd90) begin
      idx = deg[6:0];
      neg = 1'b0;
    end else if (deg <= 9'd180) begin
      idx = 7'(9'd180 - deg);
      neg = 1'b0;
    end else if (deg <= 9'd270) begin
      idx = 7'(deg - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - deg);
      neg = 1'b1;
    end
    mag = QSIN_TAB[idx];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// File: design/splat_rotated_blend_painter.sv
// top level of the rotated splat painter with its frame store
`timescale 1ns / 1ps
// usage
//   command channel: an item is taken on a rising edge with start high and busy low.
//   kind 0 paints a splat into the frame store, kind 1 reads one pixel back.
//   every transaction yields one result on pixel_*_o, marked by strobe for a
//   single cycle; the receiver cannot stall, so it must sample on that cycle.
//   a paint result is all zeros and arrives once the last box pixel is handled.
// sequence
//   a read passes the address and memory read states, then the result state raises strobe.
//   a paint checks the box, looks up sine and cosine, then handles each box pixel
//   in turn; a pixel whose target is off the image skips the read, blend and
//   write, and an empty box goes straight to the zero result.
//   the per-pixel work is the 22-step restoring divider and
//   the 16-step root, both bit-serial, plus rotation, address and the
//   read, blend and write of three channels on the frame store ports.
//   busy stays high for the whole item, so one item is in flight at a time.
// reset
//   rst_ni clears the control logic at once; the frame store is then swept to
//   zero one pixel a cycle, all IMAGE_WIDTH * IMAGE_HEIGHT pixels (262144 at the
//   default size), with busy high throughout.
module splat_rotated_blend_painter
  import srbp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       kind_i,
  input  logic [8:0] origin_x_i,
  input  logic [8:0] origin_y_i,
  input  logic [8:0] box_width_i,
  input  logic [8:0] box_height_i,
  input  logic [7:0] rotation_degrees_i,
  input  logic [7:0] splat_red_i,
  input  logic [7:0] splat_green_i,
  input  logic [7:0] splat_blue_i,
  output logic       strobe,
  output logic [7:0] pixel_red_o,
  output logic [7:0] pixel_green_o,
  output logic [7:0] pixel_blue_o
);

  // command from the sequencer, status back from the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: clear sweep, read path and per-pixel paint steps
  srbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // datapath: item registers, divider, root, rotation, blend, frame store
  srbp_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .origin_x_i         (origin_x_i),
    .origin_y_i         (origin_y_i),
    .box_width_i        (box_width_i),
    .box_height_i       (box_height_i),
    .rotation_degrees_i (rotation_degrees_i),
    .splat_red_i        (splat_red_i),
    .splat_green_i      (splat_green_i),
    .splat_blue_i       (splat_blue_i),
    .strobe             (strobe),
    .pixel_red_o        (pixel_red_o),
    .pixel_green_o      (pixel_green_o),
    .pixel_blue_o       (pixel_blue_o)
  );

endmodule

// File: design/srbp_ctrl.sv
// sequencer for the splat painter: clear, read and per-pixel paint steps
`timescale 1ns / 1ps
module srbp_ctrl
  import srbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       kind_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:      if (start) state_d = kind_i ? ST_RD_ADDR : ST_CHECK;
      ST_CHECK:     state_d = status_i.box_empty ? ST_RES_ZERO : ST_SIN;
      ST_SIN:       state_d = ST_COS;
      ST_COS:       state_d = ST_DIVY_INIT;
      ST_DIVY_INIT: state_d = ST_DIVY;
      ST_DIVY:      if (status_i.div_last) state_d = ST_CAPY;
      ST_CAPY:      state_d = ST_DIVX_INIT;
      ST_DIVX_INIT: state_d = ST_DIVX;
      ST_DIVX:      if (status_i.div_last) state_d = ST_CAPX;
      ST_CAPX:      state_d = ST_SQX;
      ST_SQX:       state_d = ST_SQY;
      ST_SQY:       state_d = ST_ROOT_INIT;
      ST_ROOT_INIT: state_d = ST_ROOT;
      ST_ROOT:      if (status_i.root_last) state_d = ST_DSEL;
      ST_DSEL:      state_d = ST_ROT_A;
      ST_ROT_A:     state_d = ST_ROT_B;
      ST_ROT_B:     state_d = ST_TX;
      ST_TX:        state_d = ST_ROT_C;
      ST_ROT_C:     state_d = ST_ROT_D;
      ST_ROT_D:     state_d = ST_TY;
      ST_TY:        state_d = ST_ADDR;
      ST_ADDR:      state_d = status_i.in_image ? ST_MEM_RD : ST_NEXT;
      ST_MEM_RD:    state_d = ST_BLEND;
      ST_BLEND:     if (status_i.blend_last) state_d = ST_WRITE;
      ST_WRITE:     state_d = ST_NEXT;
      ST_NEXT: begin
        if (!status_i.col_last) state_d = ST_DIVX_INIT;
        else if (!status_i.row_last) state_d = ST_DIVY_INIT;
        else state_d = ST_RES_ZERO;
      end
      ST_RES_ZERO:  state_d = ST_IDLE;
      ST_RD_ADDR:   state_d = ST_RD_MEM;
      ST_RD_MEM:    state_d = ST_RES_READ;
      ST_RES_READ:  state_d = ST_IDLE;
      default:      state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      ST_CLEAR:     cmd_o.op = OP_CLEAR;
      ST_IDLE:      cmd_o.op = start ? OP_LOAD : OP_NONE;
      ST_CHECK:     cmd_o.op = OP_NONE;
      ST_SIN:       cmd_o.op = OP_SIN;
      ST_COS:       cmd_o.op = OP_COS;
      ST_DIVY_INIT: cmd_o.op = OP_DIV_INIT_Y;
      ST_DIVY:      cmd_o.op = OP_DIV_STEP;
      ST_CAPY:      cmd_o.op = OP_CAP_Y;
      ST_DIVX_INIT: cmd_o.op = OP_DIV_INIT_X;
      ST_DIVX:      cmd_o.op = OP_DIV_STEP;
      ST_CAPX:      cmd_o.op = OP_CAP_X;
      ST_SQX:       cmd_o.op = OP_SQ_X;
      ST_SQY:       cmd_o.op = OP_SQ_Y;
      ST_ROOT_INIT: cmd_o.op = OP_ROOT_INIT;
      ST_ROOT:      cmd_o.op = OP_ROOT_STEP;
      ST_DSEL:      cmd_o.op = OP_DSEL;
      ST_ROT_A:     cmd_o.op = OP_ROT_A;
      ST_ROT_B:     cmd_o.op = OP_ROT_B;
      ST_TX:        cmd_o.op = OP_TX;
      ST_ROT_C:     cmd_o.op = OP_ROT_C;
      ST_ROT_D:     cmd_o.op = OP_ROT_D;
      ST_TY:        cmd_o.op = OP_TY;
      ST_ADDR:      cmd_o.op = OP_ADDR;
      ST_MEM_RD:    cmd_o.op = OP_MEM_RD;
      ST_BLEND:     cmd_o.op = OP_BLEND;
      ST_WRITE:     cmd_o.op = OP_WRITE;
      ST_NEXT:      cmd_o.op = OP_NEXT;
      ST_RES_ZERO:  cmd_o.op = OP_RES_ZERO;
      ST_RD_ADDR:   cmd_o.op = OP_RD_ADDR;
      ST_RD_MEM:    cmd_o.op = OP_MEM_RD;
      ST_RES_READ:  cmd_o.op = OP_RES_READ;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: design/srbp_datapath.sv
// datapath of the splat painter: divider, root, rotation, blend and frame store
`timescale 1ns / 1ps
`include "splat_rotated_blend_painter_macros.svh"
module srbp_datapath
  import srbp_pkg::*;
#(
  parameter int IMAGE_WIDTH  = 512,
  parameter int IMAGE_HEIGHT = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  logic [8:0] origin_x_i,
  input  logic [8:0] origin_y_i,
  input  logic [8:0] box_width_i,
  input  logic [8:0] box_height_i,
  input  logic [7:0] rotation_degrees_i,
  input  logic [7:0] splat_red_i,
  input  logic [7:0] splat_green_i,
  input  logic [7:0] splat_blue_i,
  output logic       strobe,
  output logic [7:0] pixel_red_o,
  output logic [7:0] pixel_green_o,
  output logic [7:0] pixel_blue_o
);

  localparam int DEPTH = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(IMAGE_WIDTH);
  localparam int YW    = $clog2(IMAGE_HEIGHT);

  // item registers
  logic [8:0] ox_q, oy_q, bw_q, bh_q;
  logic [7:0] hx_q, hy_q, deg_q;
  logic [2:0][7:0] col_q;
  logic [8:0] r_q, c_q;
  logic signed [15:0] sn_q, cs_q;

  // divider
  logic [21:0] num_q;
  logic [7:0]  rem_q, dv_q;
  logic [14:0] quo_q, qx_q, qy_q;

  // distance
  logic [29:0] s_q, v_q;
  logic [31:0] res_q, bit_q;
  logic [14:0] d_q;

  // rotation and address
  logic signed [26:0] acc_q;
  logic [PW-1:0] tx_q, ty_q;
  logic [AW-1:0] addr_q, clr_q;
  logic          rd_ok_q;
  logic [23:0]   rd_q;
  logic [2:0][7:0] new_q;
  logic [4:0]    step_q;

  logic [23:0] mem [DEPTH];

  // combinational helpers
  logic signed [9:0] dx_w, dy_w, dx_neg, dy_neg;
  logic [7:0]  mag_x, mag_y;
  logic [9:0]  cx_w, cy_w;
  logic [8:0]  rem_n;
  logic        div_ge;
  logic [14:0] sq_in;
  logic [29:0] sq_prod;
  logic [31:0] root_t;
  logic signed [15:0] rm_a;
  logic signed [9:0]  rm_b;
  logic signed [25:0] rot_prod;
  logic signed [26:0] acc_adj, acc_sh;
  logic [7:0]  old_ch, col_ch;
  logic [22:0] bl_old, bl_col;
  logic [8:0]  blend_sum;
  logic [1:0]  ch;
  logic        stepping;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0]   mem_wd;

  assign dx_w   = $signed(10'(c_q) - 10'(hx_q));
  assign dy_w   = $signed(10'(r_q) - 10'(hy_q));
  assign dx_neg = -dx_w;
  assign dy_neg = -dy_w;
  assign mag_x  = dx_w[9] ? dx_neg[7:0] : dx_w[7:0];
  assign mag_y  = dy_w[9] ? dy_neg[7:0] : dy_w[7:0];
  assign cx_w   = 10'(ox_q) + 10'(hx_q);
  assign cy_w   = 10'(oy_q) + 10'(hy_q);

  assign rem_n  = {rem_q, num_q[21]};
  assign div_ge = rem_n >= {1'b0, dv_q};

  assign sq_in   = (cmd_i.op == OP_SQ_X) ? qx_q : qy_q;
  assign sq_prod = sq_in * sq_in;

  assign root_t = res_q + bit_q;

  // one shared multiplier for the four rotation products
  assign rm_a     = (cmd_i.op == OP_ROT_A || cmd_i.op == OP_ROT_D) ? cs_q : sn_q;
  assign rm_b     = (cmd_i.op == OP_ROT_A || cmd_i.op == OP_ROT_C) ? dx_w : dy_w;
  assign rot_prod = rm_a * rm_b;
  // truncation toward zero of acc / 2^14
  assign acc_adj  = acc_q + (acc_q[26] ? 27'sd16383 : 27'sd0);
  assign acc_sh   = acc_adj >>> 14;

  assign ch = step_q[1:0];
  always_comb begin
    unique case (ch)
      2'd0:    begin old_ch = rd_q[7:0];   col_ch = col_q[0]; end
      2'd1:    begin old_ch = rd_q[15:8];  col_ch = col_q[1]; end
      default: begin old_ch = rd_q[23:16]; col_ch = col_q[2]; end
    endcase
  end
  assign bl_old    = old_ch * d_q;
  assign bl_col    = col_ch * (15'd16384 - d_q);
  assign blend_sum = 9'(bl_old >> 14) + 9'(bl_col >> 14);

  assign stepping = (cmd_i.op == OP_DIV_STEP) || (cmd_i.op == OP_ROOT_STEP) ||
                    (cmd_i.op == OP_BLEND);

  // status
  assign status_o.clear_done = (clr_q == AW'(DEPTH - 1));
  assign status_o.div_last   = (step_q == 5'd21);
  assign status_o.root_last  = (step_q == 5'd15);
  assign status_o.blend_last = (step_q == 5'd2);
  assign status_o.col_last   = (c_q == bw_q - 9'd1);
  assign status_o.row_last   = (r_q == bh_q - 9'd1);
  assign status_o.box_empty  = (bw_q == 9'd0) || (bh_q == 9'd0);
  assign status_o.in_image   = !tx_q[PW-1] && !ty_q[PW-1] &&
                               ($signed(tx_q) < $signed(PW'(IMAGE_WIDTH))) &&
                               ($signed(ty_q) < $signed(PW'(IMAGE_HEIGHT)));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      step_q <= '0;
      strobe <= 1'b0;
    end else begin
      step_q <= stepping ? step_q + 5'd1 : 5'd0;
      strobe <= (cmd_i.op == OP_RES_ZERO) || (cmd_i.op == OP_RES_READ);
      if (cmd_i.op == OP_CLEAR && !status_o.clear_done) clr_q <= clr_q + AW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        ox_q   <= origin_x_i;
        oy_q   <= origin_y_i;
        bw_q   <= box_width_i;
        bh_q   <= box_height_i;
        hx_q   <= box_width_i[8:1];
        hy_q   <= box_height_i[8:1];
        deg_q  <= rotation_degrees_i;
        col_q  <= {splat_blue_i, splat_green_i, splat_red_i};
        r_q    <= '0;
        c_q    <= '0;
      end
      OP_SIN: sn_q <= sine_lookup(9'(deg_q));
      OP_COS: cs_q <= sine_lookup(9'(deg_q) + 9'd90);
      OP_DIV_INIT_Y: begin
        num_q <= {mag_y, 14'd0};
        dv_q  <= (hy_q == 8'd0) ? 8'd1 : hy_q;
        rem_q <= '0;
        quo_q <= '0;
      end
      OP_DIV_INIT_X: begin
        num_q <= {mag_x, 14'd0};
        dv_q  <= (hx_q == 8'd0) ? 8'd1 : hx_q;
        rem_q <= '0;
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        num_q <= num_q << 1;
        rem_q <= div_ge ? 8'(rem_n - {1'b0, dv_q}) : rem_n[7:0];
        quo_q <= {quo_q[13:0], div_ge};
      end
      OP_CAP_Y: qy_q <= quo_q;
      OP_CAP_X: qx_q <= quo_q;
      OP_SQ_X:  s_q <= sq_prod;
      OP_SQ_Y:  s_q <= s_q + sq_prod;
      OP_ROOT_INIT: begin
        v_q   <= s_q;
        res_q <= '0;
        bit_q <= 32'h4000_0000;
      end
      OP_ROOT_STEP: begin
        if ({2'b00, v_q} >= root_t) begin
          v_q   <= 30'(32'(v_q) - root_t);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DSEL: d_q <= (s_q[29] || s_q[28]) ? 15'd16384 : res_q[14:0];
      OP_ROT_A, OP_ROT_C: acc_q <= 27'(rot_prod);
      OP_ROT_B: acc_q <= acc_q - 27'(rot_prod);
      OP_ROT_D: acc_q <= acc_q + 27'(rot_prod);
      OP_TX:    tx_q <= PW'(cx_w) + acc_sh[PW-1:0];
      OP_TY:    ty_q <= PW'(cy_w) + acc_sh[PW-1:0];
      OP_ADDR:  addr_q <= AW'(AW'(ty_q[YW-1:0]) * AW'(IMAGE_WIDTH)) + AW'(tx_q[XW-1:0]);
      OP_BLEND: new_q[ch] <= blend_sum[7:0];
      OP_NEXT: begin
        if (status_o.col_last) begin
          c_q <= '0;
          r_q <= r_q + 9'd1;
        end else begin
          c_q <= c_q + 9'd1;
        end
      end
      OP_RD_ADDR: begin
        rd_ok_q <= (13'(ox_q) < 13'(IMAGE_WIDTH)) && (13'(oy_q) < 13'(IMAGE_HEIGHT));
        addr_q  <= ((13'(ox_q) < 13'(IMAGE_WIDTH)) && (13'(oy_q) < 13'(IMAGE_HEIGHT))) ?
                   AW'(AW'(oy_q) * AW'(IMAGE_WIDTH)) + AW'(ox_q) : '0;
      end
      OP_RES_ZERO: begin
        pixel_red_o   <= '0;
        pixel_green_o <= '0;
        pixel_blue_o  <= '0;
      end
      OP_RES_READ: begin
        pixel_red_o   <= rd_ok_q ? rd_q[7:0]   : 8'd0;
        pixel_green_o <= rd_ok_q ? rd_q[15:8]  : 8'd0;
        pixel_blue_o  <= rd_ok_q ? rd_q[23:16] : 8'd0;
      end
      default: ;
    endcase
  end

  // frame store, one write and one registered read port
  assign mem_we = (cmd_i.op == OP_CLEAR) || (cmd_i.op == OP_WRITE);
  assign mem_wa = (cmd_i.op == OP_CLEAR) ? clr_q : addr_q;
  assign mem_wd = (cmd_i.op == OP_CLEAR) ? 24'd0 : {new_q[2], new_q[1], new_q[0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.op == OP_MEM_RD) rd_q <= mem[addr_q];
  end

  `SRBP_ASSERT_HOLDS(a_div_nonzero, clk_i, rst_ni, (cmd_i.op != OP_DIV_STEP) || (dv_q != 8'd0), "divider run with zero divisor")
  `SRBP_ASSERT_HOLDS(a_blend_range, clk_i, rst_ni, (cmd_i.op != OP_BLEND) || !blend_sum[8], "blend sum above 255")
  `SRBP_ASSERT_HOLDS(a_write_inside, clk_i, rst_ni, (cmd_i.op != OP_WRITE) || status_o.in_image, "frame write outside the image")
  `SRBP_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, strobe, !strobe, "result strobe held for two cycles")

endmodule
